// ===== design/shape_world_aabb_core_macros.svh =====
// ---------------------------------------------------------------------------
// shape_world_aabb_core_macros.svh
// Assertion helpers shared by the bounding box core.
// ---------------------------------------------------------------------------
`ifndef SHAPE_WORLD_AABB_CORE_MACROS_SVH
`define SHAPE_WORLD_AABB_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SWA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define SWA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/swa_pkg.sv =====
// ---------------------------------------------------------------------------
// swa_pkg
// Widths, kind codes and pipeline records for the bounding box core.
// ---------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int CW        = 20;
  localparam int QW        = 16;
  localparam int QF        = QW - 2;
  localparam int XB        = 2 * QF + 1;
  localparam int RW        = QW + 4;
  localparam int SQ_STEPS  = RW + 8;
  localparam int SQ_XW     = 2 * SQ_STEPS;
  localparam int DIV_STEPS = QF + 2;
  localparam int DIV_NW    = RW + QF + 9;
  localparam int DIV_DW    = SQ_STEPS + 1;
  localparam int ACC_W     = 64;
  localparam int PIPE_LAT  = 9 + SQ_STEPS + DIV_STEPS;

  localparam logic [1:0] KIND_SPHERE  = 2'd0;
  localparam logic [1:0] KIND_CAPSULE = 2'd1;
  localparam logic [1:0] KIND_BOX     = 2'd2;
  localparam logic [1:0] KIND_VOXEL   = 2'd3;

  typedef struct packed {
    logic [1:0]             kind;
    logic [2:0][CW-1:0]     pos;
    logic [3:0][QW-1:0]     bq;
    logic [2:0][CW-1:0]     lc;
    logic [3:0][QW-1:0]     lq;
    logic [2:0][CW-1:0]     da;
    logic [2:0][CW-1:0]     db;
  } in_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [2:0][ACC_W-1:0]  center;
    logic [2:0][CW-1:0]     da;
    logic [2:0][CW:0]       dbp;
    logic [2:0][CW:0]       dbm;
    logic [CW+1:0]          shaft;
    logic [3:0][RW-1:0]     r;
    logic                   zero;
  } side_t;

endpackage

`default_nettype wire

// ===== design/shape_world_aabb_core.sv =====
// ---------------------------------------------------------------------------
// shape_world_aabb_core
// World-space axis-aligned bounding box of one collision shape per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Input: a transfer happens on a clock edge with start high and busy low.
//   busy is low whenever the block is out of reset, so one shape may be
//   issued every cycle.
//   Output: each box appears on out_* for one cycle with out_valid high.
//   The receiver cannot stall; results follow input order, one per shape.
//   Pipeline, from input transfer to output transfer: 4 front stages, a
//   28-stage square root, a 16-stage divider for quaternion normalization,
//   then 5 matrix/extent/rounding stages.
//   Throughput: one shape per cycle; the root and divider are fully
//   pipelined, one result bit per stage.
//   Reset: synchronous, active low; clears all valid bits, busy is high
//   while reset is asserted.
// ---------------------------------------------------------------------------
`default_nettype none

`include "shape_world_aabb_core_macros.svh"

module shape_world_aabb_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [3*swa_pkg::CW-1:0]     in_body_position,
  input  wire logic [4*swa_pkg::QW-1:0]     in_body_rotation,
  input  wire logic [3*swa_pkg::CW-1:0]     in_local_center,
  input  wire logic [4*swa_pkg::QW-1:0]     in_local_rotation,
  input  wire logic [3*swa_pkg::CW-1:0]     in_dims_a,
  input  wire logic [3*swa_pkg::CW-1:0]     in_dims_b,
  output logic                              out_valid,
  output logic signed [swa_pkg::CW-1:0]     out_min_x,
  output logic signed [swa_pkg::CW-1:0]     out_min_y,
  output logic signed [swa_pkg::CW-1:0]     out_min_z,
  output logic signed [swa_pkg::CW-1:0]     out_max_x,
  output logic signed [swa_pkg::CW-1:0]     out_max_y,
  output logic signed [swa_pkg::CW-1:0]     out_max_z
);

  localparam int CW    = swa_pkg::CW;
  localparam int QW    = swa_pkg::QW;
  localparam int QF    = swa_pkg::QF;
  localparam int XB    = swa_pkg::XB;
  localparam int RW    = swa_pkg::RW;
  localparam int ACC_W = swa_pkg::ACC_W;
  localparam int RAWW  = 2 * QW + 2;
  localparam int UVW   = QW + CW + 1;
  localparam int AW3   = QW + UVW + 2;
  localparam int LENW  = 2 * RW + 1;
  localparam int MW    = 2 * QW;
  localparam int PW    = MW + CW + 2;
  localparam int SDL   = swa_pkg::SQ_STEPS + swa_pkg::DIV_STEPS;

  logic in_acc;

  assign busy   = !rst_n;
  assign in_acc = start && !busy;

  // ---------------- stage 1: input capture
  logic          s1_vld_r;
  swa_pkg::in_t  s1_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_in_r.kind <= in_kind;
      s1_in_r.pos  <= in_body_position;
      s1_in_r.bq   <= in_body_rotation;
      s1_in_r.lc   <= in_local_center;
      s1_in_r.lq   <= in_local_rotation;
      s1_in_r.da   <= in_dims_a;
      s1_in_r.db   <= in_dims_b;
    end
  end

  // ---------------- stage 2: combined quaternion, first cross product
  logic                   s2_vld_r;
  swa_pkg::in_t           s2_in_r;
  logic signed [RW-1:0]   r_nxt  [4];
  logic signed [RW-1:0]   r_s2_r [4];
  logic signed [UVW-1:0]  uv_nxt  [3];
  logic signed [UVW-1:0]  uv_s2_r [3];

  always_comb begin
    logic signed [2*QW-1:0]    pr [4][4];
    logic signed [QW+CW-1:0]   pv [4][3];
    logic signed [RAWW-1:0]    raw [4];
    logic signed [RAWW-1:0]    rnd;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pr[i][j] = $signed(s1_in_r.bq[i]) * $signed(s1_in_r.lq[j]);
      end
      for (int j = 0; j < 3; j++) begin
        pv[i][j] = $signed(s1_in_r.bq[i]) * $signed(s1_in_r.lc[j]);
      end
    end
    raw[0] = RAWW'(pr[0][0]) - RAWW'(pr[1][1]) - RAWW'(pr[2][2]) - RAWW'(pr[3][3]);
    raw[1] = RAWW'(pr[0][1]) + RAWW'(pr[1][0]) + RAWW'(pr[2][3]) - RAWW'(pr[3][2]);
    raw[2] = RAWW'(pr[0][2]) + RAWW'(pr[2][0]) + RAWW'(pr[3][1]) - RAWW'(pr[1][3]);
    raw[3] = RAWW'(pr[0][3]) + RAWW'(pr[3][0]) + RAWW'(pr[1][2]) - RAWW'(pr[2][1]);
    for (int i = 0; i < 4; i++) begin
      rnd      = (raw[i] + RAWW'(1 << (QF - 1))) >>> QF;
      r_nxt[i] = rnd[RW-1:0];
    end
    uv_nxt[0] = UVW'(pv[2][2]) - UVW'(pv[3][1]);
    uv_nxt[1] = UVW'(pv[3][0]) - UVW'(pv[1][2]);
    uv_nxt[2] = UVW'(pv[1][1]) - UVW'(pv[2][0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_in_r <= s1_in_r;
    for (int i = 0; i < 4; i++) r_s2_r[i] <= r_nxt[i];
    for (int i = 0; i < 3; i++) uv_s2_r[i] <= uv_nxt[i];
  end

  // ---------------- stage 3: second cross product, squares
  logic                   s3_vld_r;
  swa_pkg::in_t           s3_in_r;
  logic signed [RW-1:0]   r_s3_r [4];
  logic signed [2*RW-1:0] sq_s3_r [4];
  logic signed [AW3-1:0]  acc_nxt  [3];
  logic signed [AW3-1:0]  acc_s3_r [3];

  always_comb begin
    logic signed [QW+UVW-1:0] qu [4][3];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        qu[i][j] = $signed(s2_in_r.bq[i]) * uv_s2_r[j];
      end
    end
    acc_nxt[0] = AW3'(qu[0][0]) + AW3'(qu[2][2]) - AW3'(qu[3][1]);
    acc_nxt[1] = AW3'(qu[0][1]) + AW3'(qu[3][0]) - AW3'(qu[1][2]);
    acc_nxt[2] = AW3'(qu[0][2]) + AW3'(qu[1][1]) - AW3'(qu[2][0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_in_r <= s2_in_r;
    for (int i = 0; i < 4; i++) begin
      r_s3_r[i]  <= r_s2_r[i];
      sq_s3_r[i] <= r_s2_r[i] * r_s2_r[i];
    end
    for (int i = 0; i < 3; i++) acc_s3_r[i] <= acc_nxt[i];
  end

  // ---------------- stage 4: center, length, side record
  logic                         s4_vld_r;
  swa_pkg::side_t               s4_side_r;
  swa_pkg::side_t               side_nxt;
  logic [swa_pkg::SQ_XW-1:0]    s4_x_r;
  logic [swa_pkg::SQ_XW-1:0]    x_nxt;

  always_comb begin
    logic [LENW-1:0]         len2;
    logic signed [ACC_W-1:0] cen;
    logic signed [CW:0]      da1, db1;
    len2 = '0;
    for (int i = 0; i < 4; i++) begin
      len2 = len2 + LENW'(sq_s3_r[i][2*RW-1:0]);
      side_nxt.r[i] = r_s3_r[i];
    end
    x_nxt         = swa_pkg::SQ_XW'(len2) << 16;
    side_nxt.zero = (len2 == '0);
    side_nxt.kind = s3_in_r.kind;
    side_nxt.da   = s3_in_r.da;
    for (int i = 0; i < 3; i++) begin
      cen = ((ACC_W'($signed(s3_in_r.pos[i])) + ACC_W'($signed(s3_in_r.lc[i]))) <<< XB)
          + (ACC_W'(acc_s3_r[i]) <<< 2);
      side_nxt.center[i] = cen;
      da1 = (CW + 1)'($signed(s3_in_r.da[i]));
      db1 = (CW + 1)'($signed(s3_in_r.db[i]));
      side_nxt.dbp[i] = db1 + da1;
      side_nxt.dbm[i] = db1 - da1;
    end
    side_nxt.shaft = (CW + 2)'($signed(s3_in_r.da[1]))
                   - ((CW + 2)'($signed(s3_in_r.da[0])) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_side_r <= side_nxt;
    s4_x_r    <= x_nxt;
  end

  // ---------------- root and normalizing divide
  swa_pkg::side_t                  sd_r [SDL];
  logic                            sq_vld;
  logic [swa_pkg::SQ_STEPS-1:0]    sq_root;
  logic [3:0]                      dv_vld;
  logic [swa_pkg::DIV_STEPS-1:0]   dv_quo [4];
  logic [swa_pkg::DIV_NW-1:0]      dv_num [4];
  logic [swa_pkg::DIV_DW-1:0]      dv_den;

  always_ff @(posedge clk) begin
    sd_r[0] <= s4_side_r;
    for (int k = 1; k < SDL; k++) sd_r[k] <= sd_r[k-1];
  end

  swa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_x     (s4_x_r),
    .out_vld  (sq_vld),
    .out_root (sq_root)
  );

  always_comb begin
    logic [RW-1:0] ar;
    dv_den = {sq_root, 1'b0};
    for (int i = 0; i < 4; i++) begin
      ar = sd_r[swa_pkg::SQ_STEPS-1].r[i][RW-1] ? -sd_r[swa_pkg::SQ_STEPS-1].r[i]
                                                : sd_r[swa_pkg::SQ_STEPS-1].r[i];
      dv_num[i] = (swa_pkg::DIV_NW'(ar) << (QF + 9)) + swa_pkg::DIV_NW'(sq_root);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    swa_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (sq_vld),
      .in_num  (dv_num[g]),
      .in_den  (dv_den),
      .out_vld (dv_vld[g]),
      .out_quo (dv_quo[g])
    );
  end

  // ---------------- stage 5: normalized quaternion
  logic                   s5_vld_r;
  swa_pkg::side_t         s5_side_r;
  logic signed [QW-1:0]   n_nxt  [4];
  logic signed [QW-1:0]   n_s5_r [4];

  always_comb begin
    logic [swa_pkg::DIV_STEPS-1:0] mag;
    for (int i = 0; i < 4; i++) begin
      mag = (dv_quo[i] > swa_pkg::DIV_STEPS'(1 << QF)) ? swa_pkg::DIV_STEPS'(1 << QF)
                                                       : dv_quo[i];
      n_nxt[i] = sd_r[SDL-1].r[i][RW-1] ? -QW'(mag) : QW'(mag);
      if (sd_r[SDL-1].zero) begin
        n_nxt[i] = (i == 0) ? QW'(1 << QF) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= dv_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    s5_side_r <= sd_r[SDL-1];
    for (int i = 0; i < 4; i++) n_s5_r[i] <= n_nxt[i];
  end

  // ---------------- stage 6: rotation matrix, m[col][row]
  logic                   s6_vld_r;
  swa_pkg::side_t         s6_side_r;
  logic signed [MW-1:0]   m_nxt  [3][3];
  logic signed [MW-1:0]   m_s6_r [3][3];

  always_comb begin
    logic signed [MW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
    one = MW'(1) <<< (2 * QF);
    xx = n_s5_r[1] * n_s5_r[1];
    yy = n_s5_r[2] * n_s5_r[2];
    zz = n_s5_r[3] * n_s5_r[3];
    xy = n_s5_r[1] * n_s5_r[2];
    xz = n_s5_r[1] * n_s5_r[3];
    yz = n_s5_r[2] * n_s5_r[3];
    wx = n_s5_r[0] * n_s5_r[1];
    wy = n_s5_r[0] * n_s5_r[2];
    wz = n_s5_r[0] * n_s5_r[3];
    m_nxt[0][0] = one - ((yy + zz) <<< 1);
    m_nxt[0][1] = (xy + wz) <<< 1;
    m_nxt[0][2] = (xz - wy) <<< 1;
    m_nxt[1][0] = (xy - wz) <<< 1;
    m_nxt[1][1] = one - ((xx + zz) <<< 1);
    m_nxt[1][2] = (yz + wx) <<< 1;
    m_nxt[2][0] = (xz + wy) <<< 1;
    m_nxt[2][1] = (yz - wx) <<< 1;
    m_nxt[2][2] = one - ((xx + yy) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_side_r <= s5_side_r;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) m_s6_r[c][i] <= m_nxt[c][i];
    end
  end

  // ---------------- stage 7: extent products
  logic                   s7_vld_r;
  swa_pkg::side_t         s7_side_r;
  logic signed [PW-1:0]   pa_nxt [3][3];
  logic signed [PW-1:0]   pc_nxt [3][3];
  logic signed [PW-1:0]   cap_nxt [3];
  logic signed [PW-1:0]   pa_s7_r [3][3];
  logic signed [PW-1:0]   pc_s7_r [3][3];
  logic signed [PW-1:0]   cap_s7_r [3];

  always_comb begin
    logic [MW-1:0]       am;
    logic signed [CW:0]  sel;
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        am  = m_s6_r[c][i][MW-1] ? -m_s6_r[c][i] : m_s6_r[c][i];
        sel = (s6_side_r.kind == swa_pkg::KIND_VOXEL) ? $signed(s6_side_r.dbm[c])
                                                      : (CW + 1)'($signed(s6_side_r.da[c]));
        pa_nxt[i][c] = $signed({1'b0, am}) * sel;
        pc_nxt[i][c] = m_s6_r[c][i] * $signed(s6_side_r.dbp[c]);
      end
      cap_nxt[i] = m_s6_r[2][i] * $signed(s6_side_r.shaft);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_side_r <= s6_side_r;
    for (int i = 0; i < 3; i++) begin
      cap_s7_r[i] <= cap_nxt[i];
      for (int c = 0; c < 3; c++) begin
        pa_s7_r[i][c] <= pa_nxt[i][c];
        pc_s7_r[i][c] <= pc_nxt[i][c];
      end
    end
  end

  // ---------------- stage 8: extent and center sums
  logic                     s8_vld_r;
  logic signed [ACC_W-1:0]  ext_nxt [3];
  logic signed [ACC_W-1:0]  cen_nxt [3];
  logic signed [ACC_W-1:0]  ext_s8_r [3];
  logic signed [ACC_W-1:0]  cen_s8_r [3];

  always_comb begin
    logic signed [ACC_W-1:0] rad, sa, sc, cp;
    rad = ACC_W'($signed(s7_side_r.da[0])) <<< XB;
    for (int i = 0; i < 3; i++) begin
      sa = ACC_W'(pa_s7_r[i][0]) + ACC_W'(pa_s7_r[i][1]) + ACC_W'(pa_s7_r[i][2]);
      sc = ACC_W'(pc_s7_r[i][0]) + ACC_W'(pc_s7_r[i][1]) + ACC_W'(pc_s7_r[i][2]);
      cp = cap_s7_r[i][PW-1] ? -ACC_W'(cap_s7_r[i]) : ACC_W'(cap_s7_r[i]);
      cen_nxt[i] = $signed(s7_side_r.center[i]);
      case (s7_side_r.kind)
        swa_pkg::KIND_SPHERE:  ext_nxt[i] = rad;
        swa_pkg::KIND_CAPSULE: ext_nxt[i] = cp + rad;
        swa_pkg::KIND_BOX:     ext_nxt[i] = sa;
        default: begin
          ext_nxt[i] = sa;
          cen_nxt[i] = $signed(s7_side_r.center[i]) + sc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ext_s8_r[i] <= ext_nxt[i];
      cen_s8_r[i] <= cen_nxt[i];
    end
  end

  // ---------------- stage 9: round, saturate, output register
  logic                   out_valid_r;
  logic signed [CW-1:0]   lo_nxt [3];
  logic signed [CW-1:0]   hi_nxt [3];
  logic signed [CW-1:0]   lo_r [3];
  logic signed [CW-1:0]   hi_r [3];

  function automatic logic signed [CW-1:0] sat_round(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] lim;
    lim = ACC_W'(1) <<< (CW - 1);
    t   = (x + (ACC_W'(1) <<< (XB - 1))) >>> XB;
    if (t > lim - 1) begin
      t = lim - 1;
    end else if (t < -lim) begin
      t = -lim;
    end
    return t[CW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_nxt[i] = sat_round(cen_s8_r[i] - ext_s8_r[i]);
      hi_nxt[i] = sat_round(cen_s8_r[i] + ext_s8_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lo_r[i] <= lo_nxt[i];
      hi_r[i] <= hi_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_min_x = lo_r[0];
  assign out_min_y = lo_r[1];
  assign out_min_z = lo_r[2];
  assign out_max_x = hi_r[0];
  assign out_max_y = hi_r[1];
  assign out_max_z = hi_r[2];

  // ---------------- checks
  `SWA_ASSERT_IMP(a_latency, out_valid, $past(in_acc, swa_pkg::PIPE_LAT), "result without transfer")
  `SWA_ASSERT_NEVER(a_lanes, dv_vld != {4{dv_vld[0]}}, "divider lanes out of step")
  `SWA_ASSERT_IMP(a_zero, dv_vld[0], sd_r[SDL-1].zero == (sd_r[SDL-1].r == '0), "zero flag mismatch")

endmodule

`default_nettype wire

// ===== design/swa_sqrt.sv =====
// ---------------------------------------------------------------------------
// swa_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module swa_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [swa_pkg::SQ_XW-1:0]     in_x,
  output logic                               out_vld,
  output logic [swa_pkg::SQ_STEPS-1:0]       out_root
);

  localparam int N  = swa_pkg::SQ_STEPS;
  localparam int XW = swa_pkg::SQ_XW;

  logic [XW-1:0] x_r   [N];
  logic [XW-1:0] res_r [N];
  logic [XW-1:0] x_nxt   [N];
  logic [XW-1:0] res_nxt [N];
  logic [N-1:0]  vld_r;

  always_comb begin
    logic [XW-1:0] px, pr, bitv, t;
    for (int j = 0; j < N; j++) begin
      px   = (j == 0) ? in_x : x_r[(j == 0) ? 0 : j - 1];
      pr   = (j == 0) ? '0 : res_r[(j == 0) ? 0 : j - 1];
      bitv = XW'(1) << (2 * (N - 1 - j));
      t    = pr + bitv;
      if (px >= t) begin
        x_nxt[j]   = px - t;
        res_nxt[j] = (pr >> 1) + bitv;
      end else begin
        x_nxt[j]   = px;
        res_nxt[j] = pr >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      x_r[j]   <= x_nxt[j];
      res_r[j] <= res_nxt[j];
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = res_r[N-1][N-1:0];

endmodule

`default_nettype wire

// ===== design/swa_div.sv =====
// ---------------------------------------------------------------------------
// swa_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module swa_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [swa_pkg::DIV_NW-1:0]    in_num,
  input  wire logic [swa_pkg::DIV_DW-1:0]    in_den,
  output logic                               out_vld,
  output logic [swa_pkg::DIV_STEPS-1:0]      out_quo
);

  localparam int N    = swa_pkg::DIV_STEPS;
  localparam int NW   = swa_pkg::DIV_NW;
  localparam int DW   = swa_pkg::DIV_DW;
  localparam int CMPW = DW + N;

  logic [NW-1:0] rem_r [N];
  logic [DW-1:0] den_r [N];
  logic [N-1:0]  quo_r [N];
  logic [NW-1:0] rem_nxt [N];
  logic [DW-1:0] den_nxt [N];
  logic [N-1:0]  quo_nxt [N];
  logic [N-1:0]  vld_r;

  always_comb begin
    logic [NW-1:0]   prem;
    logic [DW-1:0]   pden;
    logic [N-1:0]    pquo;
    logic [CMPW-1:0] ds;
    for (int j = 0; j < N; j++) begin
      prem = (j == 0) ? in_num : rem_r[(j == 0) ? 0 : j - 1];
      pden = (j == 0) ? in_den : den_r[(j == 0) ? 0 : j - 1];
      pquo = (j == 0) ? '0 : quo_r[(j == 0) ? 0 : j - 1];
      ds   = CMPW'(pden) << (N - 1 - j);
      den_nxt[j] = pden;
      if (CMPW'(prem) >= ds) begin
        rem_nxt[j] = prem - ds[NW-1:0];
        quo_nxt[j] = {pquo[N-2:0], 1'b1};
      end else begin
        rem_nxt[j] = prem;
        quo_nxt[j] = {pquo[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      rem_r[j] <= rem_nxt[j];
      den_r[j] <= den_nxt[j];
      quo_r[j] <= quo_nxt[j];
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_quo = quo_r[N-1];

endmodule

`default_nettype wire

// ===== tb/shape_world_aabb_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// shape_world_aabb_core_tb
// Self-checking bench: drives shapes of every kind with random gaps, predicts
// each world-space bounding box in fixed point and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module shape_world_aabb_core_tb;

  localparam int CW = swa_pkg::CW;
  localparam int QW = swa_pkg::QW;
  localparam int QF = swa_pkg::QF;
  localparam int XB = swa_pkg::XB;

  typedef logic [5:0][CW-1:0] box_t;  // min x,y,z then max x,y,z

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic [3*CW-1:0] in_body_position = '0;
  logic [4*QW-1:0] in_body_rotation = '0;
  logic [3*CW-1:0] in_local_center = '0;
  logic [4*QW-1:0] in_local_rotation = '0;
  logic [3*CW-1:0] in_dims_a = '0;
  logic [3*CW-1:0] in_dims_b = '0;
  logic out_valid;
  logic signed [CW-1:0] out_min_x, out_min_y, out_min_z;
  logic signed [CW-1:0] out_max_x, out_max_y, out_max_z;

  box_t expected_boxes[$];
  int errors = 0;
  int sent = 0;
  int boxes_checked = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  bit burst_mode = 1'b0;

  shape_world_aabb_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_body_position(in_body_position),
    .in_body_rotation(in_body_rotation), .in_local_center(in_local_center),
    .in_local_rotation(in_local_rotation), .in_dims_a(in_dims_a),
    .in_dims_b(in_dims_b), .out_valid(out_valid),
    .out_min_x(out_min_x), .out_min_y(out_min_y), .out_min_z(out_min_z),
    .out_max_x(out_max_x), .out_max_y(out_max_y), .out_max_z(out_max_z)
  );

  always #6 clk = ~clk;

  initial begin
    #5ms;
    $display("Timeout with %0d boxes outstanding", expected_boxes.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint coord_at(logic [3*CW-1:0] v, int i);
    logic [CW-1:0] f;
    f = v[i*CW +: CW];
    return {{(64-CW){f[CW-1]}}, f};
  endfunction

  function automatic longint quat_at(logic [4*QW-1:0] v, int i);
    logic [QW-1:0] f;
    f = v[i*QW +: QW];
    return {{(64-QW){f[QW-1]}}, f};
  endfunction

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [CW-1:0] round_sat(longint x);
    longint lim, r;
    lim = longint'(1) << (CW - 1);
    r = (x + (longint'(1) << (XB - 1))) >>> XB;
    if (r > lim - 1) r = lim - 1;
    if (r < -lim) r = -lim;
    return r[CW-1:0];
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic box_t world_bounds(logic [1:0] kind, logic [3*CW-1:0] pos_v,
                                        logic [4*QW-1:0] bq_v, logic [3*CW-1:0] lc_v,
                                        logic [4*QW-1:0] lq_v, logic [3*CW-1:0] da_v,
                                        logic [3*CW-1:0] db_v);
    longint p[3], v[3], da[3], db[3], bq[4], lq[4], uv[3], uuv[3];
    longint r[4], n[4], m[3][3], ctr[3], ext[3];
    longint len2, s, num, mg, one, shaft;
    box_t b;
    for (int i = 0; i < 3; i++) begin
      p[i] = coord_at(pos_v, i);
      v[i] = coord_at(lc_v, i);
      da[i] = coord_at(da_v, i);
      db[i] = coord_at(db_v, i);
    end
    for (int i = 0; i < 4; i++) begin
      bq[i] = quat_at(bq_v, i);
      lq[i] = quat_at(lq_v, i);
    end
    uv[0] = bq[2] * v[2] - bq[3] * v[1];
    uv[1] = bq[3] * v[0] - bq[1] * v[2];
    uv[2] = bq[1] * v[1] - bq[2] * v[0];
    uuv[0] = bq[2] * uv[2] - bq[3] * uv[1];
    uuv[1] = bq[3] * uv[0] - bq[1] * uv[2];
    uuv[2] = bq[1] * uv[1] - bq[2] * uv[0];
    for (int i = 0; i < 3; i++)
      ctr[i] = (p[i] <<< XB) + 2 * ((v[i] <<< (2 * QF)) + 2 * (bq[0] * uv[i] + uuv[i]));
    r[0] = bq[0] * lq[0] - bq[1] * lq[1] - bq[2] * lq[2] - bq[3] * lq[3];
    r[1] = bq[0] * lq[1] + bq[1] * lq[0] + bq[2] * lq[3] - bq[3] * lq[2];
    r[2] = bq[0] * lq[2] + bq[2] * lq[0] + bq[3] * lq[1] - bq[1] * lq[3];
    r[3] = bq[0] * lq[3] + bq[3] * lq[0] + bq[1] * lq[2] - bq[2] * lq[1];
    len2 = 0;
    for (int i = 0; i < 4; i++) begin
      r[i] = (r[i] + (longint'(1) << (QF - 1))) >>> QF;
      len2 += r[i] * r[i];
    end
    if (len2 == 0) begin
      n[0] = longint'(1) << QF;
      n[1] = 0; n[2] = 0; n[3] = 0;
    end else begin
      s = int_sqrt(len2 << 16);
      for (int i = 0; i < 4; i++) begin
        num = mag(r[i]) << (QF + 8);
        mg = (2 * num + s) / (2 * s);
        if (mg > (longint'(1) << QF)) mg = longint'(1) << QF;
        n[i] = r[i] < 0 ? -mg : mg;
      end
    end
    one = longint'(1) << (2 * QF);
    m[0][0] = one - 2 * (n[2] * n[2] + n[3] * n[3]);
    m[0][1] = 2 * (n[1] * n[2] + n[0] * n[3]);
    m[0][2] = 2 * (n[1] * n[3] - n[0] * n[2]);
    m[1][0] = 2 * (n[1] * n[2] - n[0] * n[3]);
    m[1][1] = one - 2 * (n[1] * n[1] + n[3] * n[3]);
    m[1][2] = 2 * (n[2] * n[3] + n[0] * n[1]);
    m[2][0] = 2 * (n[1] * n[3] + n[0] * n[2]);
    m[2][1] = 2 * (n[2] * n[3] - n[0] * n[1]);
    m[2][2] = one - 2 * (n[1] * n[1] + n[2] * n[2]);
    shaft = da[1] - 2 * da[0];
    for (int i = 0; i < 3; i++) begin
      ext[i] = 0;
      case (kind)
        swa_pkg::KIND_SPHERE:  ext[i] = da[0] <<< XB;
        swa_pkg::KIND_CAPSULE: ext[i] = mag(m[2][i] * shaft) + (da[0] <<< XB);
        swa_pkg::KIND_BOX: begin
          for (int c = 0; c < 3; c++) ext[i] += mag(m[c][i]) * da[c];
        end
        default: begin
          for (int c = 0; c < 3; c++) begin
            ctr[i] += m[c][i] * (db[c] + da[c]);
            ext[i] += mag(m[c][i]) * (db[c] - da[c]);
          end
        end
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      b[i] = round_sat(ctr[i] - ext[i]);
      b[3+i] = round_sat(ctr[i] + ext[i]);
    end
    return b;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t: mismatch %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    box_t got, want;
    string names[6];
    names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
    if (rst_n && out_valid) begin
      got = {out_max_z, out_max_y, out_max_x, out_min_z, out_min_y, out_min_x};
      if (expected_boxes.size() == 0) begin
        report_mismatch("unexpected box transfer", 1, 0);
      end else begin
        want = expected_boxes.pop_front();
        boxes_checked++;
        for (int i = 0; i < 6; i++)
          if (got[i] !== want[i])
            report_mismatch(names[i], $signed(got[i]), $signed(want[i]));
      end
    end
  end

  task automatic send_shape(logic [1:0] kind, logic [3*CW-1:0] pos, logic [4*QW-1:0] bq,
                            logic [3*CW-1:0] lc, logic [4*QW-1:0] lq,
                            logic [3*CW-1:0] da, logic [3*CW-1:0] db);
    int gap;
    bit was_busy;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_kind = kind;
    in_body_position = pos;
    in_body_rotation = bq;
    in_local_center = lc;
    in_local_rotation = lq;
    in_dims_a = da;
    in_dims_b = db;
    forever begin
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
    expected_boxes.push_back(world_bounds(kind, pos, bq, lc, lq, da, db));
    kind_count[kind]++;
    sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    wait (expected_boxes.size() == 0);
    @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return CW'($urandom());
      1:       return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [QW-1:0] rand_qc();
    case ($urandom_range(0, 7))
      0:       return QW'($urandom());
      1:       return '0;
      default: return QW'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [3*CW-1:0] rand_vec();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic [4*QW-1:0] rand_quat();
    if ($urandom_range(0, 15) == 0) return '0;
    return {rand_qc(), rand_qc(), rand_qc(), rand_qc()};
  endfunction

  localparam logic [4*QW-1:0] Q_ID = 64'h0000_0000_0000_4000;
  localparam logic [4*QW-1:0] Q_Z90 = 64'h2D41_0000_0000_2D41;
  localparam logic [3*CW-1:0] V_MAX = {3{20'h7FFFF}};
  localparam logic [3*CW-1:0] V_MIN = {3{20'h80000}};
  localparam logic [3*CW-1:0] V_ONE = {3{20'h00100}};

  task automatic test_each_kind;
    for (int k = 0; k < 4; k++) begin
      send_shape(k[1:0], V_ONE, Q_ID, V_ONE, Q_ID, {20'h00300, 20'h00200, 20'h00100},
                 {20'h00600, 20'h00500, 20'h00400});
      send_shape(k[1:0], rand_vec(), Q_Z90, rand_vec(), Q_Z90, rand_vec(), rand_vec());
    end
  endtask

  task automatic test_extremes;
    for (int k = 0; k < 4; k++) begin
      send_shape(k[1:0], V_MAX, '1, V_MAX, '1, V_MAX, V_MAX);
      send_shape(k[1:0], V_MIN, {4{16'h8000}}, V_MIN, {4{16'h8000}}, V_MIN, V_MIN);
      send_shape(k[1:0], V_MAX, {4{16'h7FFF}}, V_MIN, {4{16'h7FFF}}, V_MIN, V_MAX);
    end
  endtask

  task automatic test_special_cases;
    // zero combined rotation falls back to identity
    send_shape(swa_pkg::KIND_BOX, V_ONE, '0, V_ONE, Q_Z90, V_ONE, '0);
    send_shape(swa_pkg::KIND_VOXEL, V_ONE, Q_Z90, V_ONE, '0, V_MIN, V_ONE);
    // negative sizes, and a capsule with a negative shaft
    send_shape(swa_pkg::KIND_BOX, '0, Q_Z90, '0, Q_ID, {3{20'hFFF00}}, '0);
    send_shape(swa_pkg::KIND_SPHERE, '0, Q_ID, '0, '1, {40'h0, 20'hFFE00}, '1);
    send_shape(swa_pkg::KIND_CAPSULE, '0, Q_Z90, V_ONE, Q_Z90,
               {20'h0, 20'h00100, 20'h00400}, '1);
    send_shape(swa_pkg::KIND_CAPSULE, V_ONE, Q_ID, '0, Q_Z90,
               {20'h0, 20'h00800, 20'hFFF00}, '0);
  endtask

  task automatic test_random(int count);
    int left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        burst_mode = $urandom_range(0, 3) == 0;
        left = $urandom_range(10, 60);
      end
      left--;
      send_shape(2'($urandom_range(0, 3)), rand_vec(), rand_quat(), rand_vec(), rand_quat(),
                 rand_vec(), rand_vec());
      if (i == count / 2) drain;
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_each_kind;
    test_extremes;
    test_special_cases;
    drain;
    test_random(1720);
    drain;
    repeat (swa_pkg::PIPE_LAT + 20) @(negedge clk);
    $display("Covered %0d shapes (sphere %0d, capsule %0d, box %0d, voxel %0d)",
             sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("%0d boxes checked with random gaps and back-to-back bursts", boxes_checked);
    if (errors == 0 && expected_boxes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d boxes missing", errors, expected_boxes.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/swa_pkg.sv
design/swa_sqrt.sv
design/swa_div.sv
design/shape_world_aabb_core.sv
tb/shape_world_aabb_core_tb.sv
